/* hdl/assert_macros.svh */
// Assertion macros shared by the mapper RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds in the cycle after cond.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Check that expr is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* hdl/cbm_pkg.sv */
// Types and constants for the cartridge bank mapper.
// No dependencies; used by the channel interfaces and all mapper modules.
`default_nettype none

package cbm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 18;
    localparam int PRG_SLOTS  = 3;
    localparam int CHR_SLOTS  = 8;
    localparam int PRG_BANK_W = 5;
    localparam int CHR_BANK_W = 8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PRG   = 2'd2,
        OP_CHR   = 2'd3
    } t_opcode;

    // Register group selected by address bits 13:12 when bits 15 and 14 are set
    localparam logic [1:0] RGN_IRQ_CTRL  = 2'd0;
    localparam logic [1:0] RGN_IRQ_ACK   = 2'd1;
    localparam logic [1:0] RGN_BANK_SEL  = 2'd2;
    localparam logic [1:0] RGN_BANK_DATA = 2'd3;

    // Action of a bank data write, from address bits 11:10
    localparam logic [1:0] FN_PRG_HI  = 2'b00;
    localparam logic [1:0] FN_NONE    = 2'b01;
    localparam logic [1:0] FN_MIRROR  = 2'b10;
    localparam logic [1:0] FN_CHR     = 2'b11;

    typedef logic [PRG_SLOTS-1:0][PRG_BANK_W-1:0] t_prg_table;
    typedef logic [CHR_SLOTS-1:0][CHR_BANK_W-1:0] t_chr_table;

    typedef struct packed {
        t_prg_table prg;
        t_chr_table chr;
    } t_bank_map;

endpackage

`default_nettype wire

/* hdl/cbm_channels.sv */
// Valid/ready channel interfaces for mapper requests and responses.
// Depends on cbm_pkg for field widths.
`default_nettype none

interface cbm_req_if;
    import cbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output opcode, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input bus_address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    import cbm_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAP_W-1:0] mapped_address;
    logic             irq_line;
    logic             vertical_mirror;

    modport source (output valid, output mapped_address, output irq_line,
                    output vertical_mirror, input ready);
    modport sink   (input valid, input mapped_address, input irq_line,
                    input vertical_mirror, output ready);
endinterface

`default_nettype wire

/* hdl/cartridge_bank_mapper_with_irq.sv */
// Cartridge bank mapper with a CPU-cycle IRQ counter: top level.
// Depends on cbm_pkg, cbm_channels, cbm_xlate and assert_macros.svh.
//
//  Channel  | Dir | Handshake    | Payload
//  ---------+-----+--------------+--------------------------------------------
//  i_req    | in  | valid/ready  | opcode, bus_address, write_data
//  o_rsp    | out | valid/ready  | mapped_address, irq_line, vertical_mirror
//
// Each request is decoded and applied to the mapper registers; the response is
// captured in the output register in the cycle after accept.
// A request can be accepted every cycle, limited only by the output register.
// i_req.ready drops only while the output register holds an untaken response.
// Synchronous active-low reset clears all mapper registers to zero.
`default_nettype none

module cartridge_bank_mapper_with_irq #(
    parameter int PRG_BANK_COUNT = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cbm_req_if.sink  i_req,
    cbm_rsp_if.source o_rsp
);
    import cbm_pkg::*;
    `include "assert_macros.svh"

    // Mapper state
    logic [3:0][3:0]  r_latch, n_latch;
    logic [15:0]      r_counter, n_counter;
    logic [2:0]       r_ctrl, n_ctrl;
    logic             r_count_en, n_count_en;
    logic             r_irq_pending, n_irq_pending;
    logic [7:0]       r_bank_sel, n_bank_sel;
    t_bank_map        r_banks, n_banks;
    logic             r_mirror, n_mirror;

    // Output register
    logic             r_out_valid;
    logic [MAP_W-1:0] r_mapped;
    logic             r_irq_line;
    logic             r_vmirror;

    logic             w_accept;
    t_opcode          op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [MAP_W-1:0] w_mapped;

    assign op       = t_opcode'(i_req.opcode);
    assign addr     = i_req.bus_address;
    assign data     = i_req.write_data;
    assign w_accept = i_req.valid && i_req.ready;

    // Take a new request whenever the output register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    // Translate addresses from the bank tables as they stand before the request
    cbm_xlate #(
        .PRG_BANK_COUNT (PRG_BANK_COUNT)
    ) u_xlate (
        .i_opcode  (op),
        .i_address (addr),
        .i_banks   (r_banks),
        .o_mapped  (w_mapped)
    );

    // Compute the register updates for the accepted request
    always_comb begin
        n_latch       = r_latch;
        n_counter     = r_counter;
        n_ctrl        = r_ctrl;
        n_count_en    = r_count_en;
        n_irq_pending = r_irq_pending;
        n_bank_sel    = r_bank_sel;
        n_banks       = r_banks;
        n_mirror      = r_mirror;
        if (w_accept) begin
            unique case (op)
                OP_TICK: begin
                    if (r_count_en) begin
                        if (&r_counter) begin
                            n_counter     = r_latch;
                            n_irq_pending = 1'b1;
                        end else begin
                            n_counter = r_counter + 16'd1;
                        end
                    end
                end
                OP_WRITE: begin
                    if (addr[15] && !addr[14]) begin
                        // Load one nibble of the reload latch
                        n_latch[addr[13:12]] = data[3:0];
                    end else if (addr[15]) begin
                        unique case (addr[13:12])
                            RGN_IRQ_CTRL: begin
                                n_ctrl        = data[2:0] & 3'b101;
                                n_count_en    = data[1];
                                n_irq_pending = 1'b0;
                                if (data[1]) begin
                                    n_counter = r_latch;
                                end
                            end
                            RGN_IRQ_ACK: begin
                                n_count_en    = r_ctrl[0];
                                n_irq_pending = 1'b0;
                            end
                            RGN_BANK_SEL: begin
                                n_bank_sel = data;
                            end
                            RGN_BANK_DATA: begin
                                // Low nibble of the PRG slot picked by bank select
                                if (r_bank_sel[3:2] == 2'd0 && r_bank_sel[1:0] != 2'd0) begin
                                    n_banks.prg[r_bank_sel[1:0] - 2'd1][3:0] = data[3:0];
                                end
                                unique case (addr[11:10])
                                    FN_PRG_HI: begin
                                        if (addr[1:0] != 2'd3) begin
                                            n_banks.prg[addr[1:0]][4] = data[4];
                                        end
                                    end
                                    FN_MIRROR: begin
                                        n_mirror = data[0];
                                    end
                                    FN_CHR: begin
                                        n_banks.chr[addr[2:0]] = data;
                                    end
                                    FN_NONE: begin
                                        n_mirror = r_mirror;
                                    end
                                endcase
                            end
                        endcase
                    end
                end
                OP_PRG, OP_CHR: begin
                    n_mirror = r_mirror;
                end
            endcase
        end
    end

    // Hold or advance the mapper registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch       <= '0;
            r_counter     <= '0;
            r_ctrl        <= '0;
            r_count_en    <= 1'b0;
            r_irq_pending <= 1'b0;
            r_bank_sel    <= '0;
            r_banks       <= '0;
            r_mirror      <= 1'b0;
        end else begin
            r_latch       <= n_latch;
            r_counter     <= n_counter;
            r_ctrl        <= n_ctrl;
            r_count_en    <= n_count_en;
            r_irq_pending <= n_irq_pending;
            r_bank_sel    <= n_bank_sel;
            r_banks       <= n_banks;
            r_mirror      <= n_mirror;
        end
    end

    // Mark the output register full on accept, empty once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mapped   <= w_mapped;
            r_irq_line <= n_irq_pending;
            r_vmirror  <= n_mirror;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.mapped_address  = r_mapped;
    assign o_rsp.irq_line        = r_irq_line;
    assign o_rsp.vertical_mirror = r_vmirror;

    // Checks
    `ASSERT_NEXT(a_wrap_reload, i_clk, i_rst_n, w_accept && op == OP_TICK && r_count_en && (&r_counter), r_irq_pending && r_counter == $past(r_latch), "counter wrap did not reload and raise IRQ")
    `ASSERT_NEXT(a_irq_ack, i_clk, i_rst_n, w_accept && op == OP_WRITE && addr[15:13] == 3'b110, !r_irq_pending, "IRQ not acknowledged by control write")
    `ASSERT_NEXT(a_rsp_loaded, i_clk, i_rst_n, w_accept, r_out_valid && r_irq_line == r_irq_pending, "accepted request left no response")
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_rsp.ready && i_req.ready, "request taken over a stalled response")

endmodule

`default_nettype wire

/* hdl/cbm_xlate.sv */
// PRG and CHR address translation through the current bank tables.
// Depends on cbm_pkg; instantiated by cartridge_bank_mapper_with_irq.
`default_nettype none

module cbm_xlate #(
    parameter int PRG_BANK_COUNT = 32
) (
    input  cbm_pkg::t_opcode                 i_opcode,
    input  logic [cbm_pkg::ADDR_W-1:0]       i_address,
    input  cbm_pkg::t_bank_map               i_banks,
    output logic [cbm_pkg::MAP_W-1:0]        o_mapped
);
    import cbm_pkg::*;

    localparam logic [PRG_BANK_W:0]   BANK_N     = (PRG_BANK_W + 1)'(PRG_BANK_COUNT);
    localparam logic [PRG_BANK_W-1:0] LAST_BANK  = PRG_BANK_W'(PRG_BANK_COUNT - 1);
    localparam int                    WRAP_STEPS = ((2 ** PRG_BANK_W) - 1) / PRG_BANK_COUNT;

    // Reduce a bank number modulo the ROM bank count by repeated subtraction
    function automatic logic [PRG_BANK_W-1:0] f_wrap(input logic [PRG_BANK_W-1:0] bank);
        logic [PRG_BANK_W:0] v;
        v = {1'b0, bank};
        for (int k = 0; k < WRAP_STEPS; k++) begin
            if (v >= BANK_N) begin
                v = v - BANK_N;
            end
        end
        return v[PRG_BANK_W-1:0];
    endfunction

    logic [1:0]            prg_slot;
    logic [PRG_BANK_W-1:0] prg_bank;
    logic [2:0]            chr_slot;

    // Look up the bank for the slot and splice in the in-bank offset
    always_comb begin
        prg_slot = i_address[14:13];
        chr_slot = i_address[12:10];
        prg_bank = LAST_BANK;
        o_mapped = '0;
        unique case (i_opcode)
            OP_PRG: begin
                if (prg_slot != 2'd3) begin
                    prg_bank = f_wrap(i_banks.prg[prg_slot]);
                end
                if (i_address[15]) begin
                    o_mapped = {prg_bank, i_address[12:0]};
                end
            end
            OP_CHR: begin
                if (i_address[15:13] == 3'd0) begin
                    o_mapped = {i_banks.chr[chr_slot], i_address[9:0]};
                end
            end
            OP_TICK, OP_WRITE: begin
                o_mapped = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
